>>> sv/usb_standard_request_handler_unit_macros.svh
// Assertion macros for the USB standard request handler.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef USB_STANDARD_REQUEST_HANDLER_UNIT_MACROS_SVH
`define USB_STANDARD_REQUEST_HANDLER_UNIT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define USRH_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that a condition never holds outside reset
`define USRH_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/usrh_pkg.sv
// Package for the USB standard request handler: request codes, reply codes,
// device states and the packed result word. No dependencies.
package usrh_pkg;

	localparam int NumInterfacesDefault = 4;
	localparam int NumEndpointsDefault  = 16;

	localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

	localparam logic [4:0] RCP_DEVICE    = 5'd0;
	localparam logic [4:0] RCP_INTERFACE = 5'd1;
	localparam logic [4:0] RCP_ENDPOINT  = 5'd2;

	localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'd0;
	localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'd1;

	localparam logic [7:0] TYPE_GET_DESCRIPTOR = 8'h80;
	localparam logic [7:0] DESC_DEVICE = 8'd1;
	localparam logic [7:0] DESC_CONFIG = 8'd2;
	localparam logic [7:0] DESC_STRING = 8'd3;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_BYTES  = 3'd1;
	localparam logic [2:0] KIND_DEVICE = 3'd2;
	localparam logic [2:0] KIND_CONFIG = 3'd3;
	localparam logic [2:0] KIND_STRING = 3'd4;

	localparam logic [1:0] ST_DEFAULT      = 2'd0;
	localparam logic [1:0] ST_ADDR_PENDING = 2'd1;
	localparam logic [1:0] ST_ADDRESSED    = 2'd2;
	localparam logic [1:0] ST_CONFIGURED   = 2'd3;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_STALL   = 2'd1;
	localparam logic [1:0] ACT_UNSTALL = 2'd2;

	localparam logic [2:0] REG_SELF_POWERED = 3'd0;

	typedef struct packed {
		logic [4:0] pad;
		logic [1:0] endpoint_action;
		logic       endpoints_reinit;
		logic [1:0] new_device_state;
		logic [1:0] reply_length;
		logic [7:0] reply_byte_high;
		logic [7:0] reply_byte_low;
		logic [7:0] descriptor_index;
		logic [2:0] reply_kind;
		logic       claimed;
	} result_t;

endpackage

>>> sv/usb_standard_request_handler_unit.sv
// Top level of the USB standard (chapter 9) request handler.
// Depends on usrh_pkg and usb_standard_request_handler_unit_macros.svh.
//
//  channel  direction  word                                   handshake
//  s_*      in         setup request, 48-bit tdata           tvalid/tready
//  m_*      out        request result, 40-bit tdata          tvalid/tready
//  apb      in         self_powered register at address 0    psel/penable/pwrite
//
// One word per cycle is accepted while the output is not stalled. The
// accept edge reads the alternate-setting and halt memories, the next
// stage decodes, writes back and loads the output register.
// Reset clears device state, configuration, wakeup flag and all valid bits;
// self_powered resets to 1. A stalled output holds the decode stage, which
// in turn holds the input.
`include "usb_standard_request_handler_unit_macros.svh"

module usb_standard_request_handler_unit #(
	parameter int NUM_INTERFACES = usrh_pkg::NumInterfacesDefault,
	parameter int NUM_ENDPOINTS  = usrh_pkg::NumEndpointsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // request_type, request_code, value_word, index_word
	output logic        m_tvalid,
	input  logic        m_tready,
	// claimed, reply_kind, descriptor_index, reply_byte_low, reply_byte_high,
	// reply_length, new_device_state, endpoints_reinit, endpoint_action
	output logic [39:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IfW    = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;
	localparam int HaltN  = 2 * NUM_ENDPOINTS;
	localparam int HaltW  = $clog2(HaltN);

	// memories
	logic [7:0] alt_mem [NUM_INTERFACES];
	logic       halt_mem [HaltN];
	logic [NUM_INTERFACES-1:0] alt_vld_q;
	logic [HaltN-1:0]          halt_vld_q;

	// scalar state
	logic [1:0] dev_state_q;
	logic [7:0] active_cfg_q;
	logic       wakeup_q;
	logic       self_powered_q;

	// decode stage
	logic        valid_s1;
	logic [7:0]  rtype_s1, code_s1;
	logic [15:0] wval_s1, widx_s1;
	logic [IfW-1:0]   aidx_s1;
	logic [HaltW-1:0] hidx_s1;
	logic [7:0]  alt_rd_s1;
	logic        halt_rd_s1;

	// last write, for forwarding
	logic             alt_wen_q, halt_wen_q;
	logic [IfW-1:0]   alt_wa_q;
	logic [HaltW-1:0] halt_wa_q;
	logic [7:0]       alt_wd_q;
	logic             halt_wd_q;

	logic    out_vld_q;
	usrh_pkg::result_t out_q, res;

	logic go_s1, accept;
	logic [IfW-1:0]   s_aidx;
	logic [HaltW-1:0] s_hidx;
	logic [4:0]       s_hfull;

	logic [4:0] recip;
	logic [7:0] vlo, vhi, intf;
	logic [3:0] epnum;
	logic       std, if_ok, ep_ok;
	logic [7:0] alt_val;
	logic       halt_val;
	logic       alt_we, halt_we, halt_wd, cfg_set;
	logic [1:0] nstate;
	logic [7:0] ncfg;
	logic       nwake;

	logic out_quiet, out_cfg_state, out_len_bad;

	assign go_s1    = !out_vld_q || m_tready;
	assign s_tready = !valid_s1 || go_s1;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;
	assign pready   = 1'b1;
	assign prdata   = {31'd0, self_powered_q};

	assign s_aidx  = s_tdata[32 +: IfW];
	assign s_hfull = {s_tdata[35:32], s_tdata[39]};
	assign s_hidx  = s_hfull[HaltW-1:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			rtype_s1   <= s_tdata[7:0];
			code_s1    <= s_tdata[15:8];
			wval_s1    <= s_tdata[31:16];
			widx_s1    <= s_tdata[47:32];
			aidx_s1    <= s_aidx;
			hidx_s1    <= s_hidx;
			alt_rd_s1  <= alt_mem[s_aidx];
			halt_rd_s1 <= halt_mem[s_hidx];
		end
		if (valid_s1 && go_s1 && alt_we) begin
			alt_mem[aidx_s1] <= vlo;
		end
		if (valid_s1 && go_s1 && halt_we) begin
			halt_mem[hidx_s1] <= halt_wd;
		end
	end

	always_comb begin
		recip = rtype_s1[4:0];
		vlo   = wval_s1[7:0];
		vhi   = wval_s1[15:8];
		intf  = widx_s1[7:0];
		epnum = widx_s1[3:0];
		std   = (rtype_s1[6:5] == 2'd0);
		if_ok = ({1'b0, intf} < 9'(NUM_INTERFACES));
		ep_ok = ({1'b0, epnum} < 5'(NUM_ENDPOINTS));

		alt_val = 8'd0;
		if (if_ok && alt_vld_q[aidx_s1]) begin
			alt_val = (alt_wen_q && alt_wa_q == aidx_s1) ? alt_wd_q : alt_rd_s1;
		end
		halt_val = 1'b0;
		if (ep_ok && halt_vld_q[hidx_s1]) begin
			halt_val = (halt_wen_q && halt_wa_q == hidx_s1) ? halt_wd_q : halt_rd_s1;
		end

		res     = '0;
		alt_we  = 1'b0;
		halt_we = 1'b0;
		halt_wd = 1'b0;
		cfg_set = 1'b0;
		nstate  = dev_state_q;
		ncfg    = active_cfg_q;
		nwake   = wakeup_q;

		if (std) begin
			case (code_s1)
				usrh_pkg::REQ_SET_ADDRESS: begin
					res.claimed = 1'b1;
					nstate = usrh_pkg::ST_ADDR_PENDING;
				end
				usrh_pkg::REQ_GET_DESCRIPTOR: begin
					if (rtype_s1 == usrh_pkg::TYPE_GET_DESCRIPTOR) begin
						if (vhi == usrh_pkg::DESC_DEVICE) begin
							res.claimed = 1'b1;
							res.reply_kind = usrh_pkg::KIND_DEVICE;
						end else if (vhi == usrh_pkg::DESC_CONFIG) begin
							res.claimed = 1'b1;
							res.reply_kind = usrh_pkg::KIND_CONFIG;
							res.descriptor_index = vlo;
						end else if (vhi == usrh_pkg::DESC_STRING) begin
							res.claimed = 1'b1;
							res.reply_kind = usrh_pkg::KIND_STRING;
							res.descriptor_index = vlo;
						end
					end
				end
				usrh_pkg::REQ_SET_CONFIGURATION: begin
					res.claimed = 1'b1;
					res.endpoints_reinit = 1'b1;
					cfg_set = 1'b1;
					ncfg = vlo;
					nstate = (vlo == 8'd0) ? usrh_pkg::ST_ADDRESSED : usrh_pkg::ST_CONFIGURED;
				end
				usrh_pkg::REQ_GET_CONFIGURATION: begin
					res.claimed = 1'b1;
					res.reply_kind = usrh_pkg::KIND_BYTES;
					res.reply_byte_low = active_cfg_q;
					res.reply_length = 2'd1;
				end
				usrh_pkg::REQ_GET_STATUS: begin
					if (recip == usrh_pkg::RCP_DEVICE) begin
						res.claimed = 1'b1;
						res.reply_byte_low = {6'd0, wakeup_q, self_powered_q};
					end else if (recip == usrh_pkg::RCP_INTERFACE) begin
						res.claimed = 1'b1;
					end else if (recip == usrh_pkg::RCP_ENDPOINT && ep_ok) begin
						res.claimed = 1'b1;
						res.reply_byte_low = {7'd0, halt_val};
					end
					if (res.claimed) begin
						res.reply_kind = usrh_pkg::KIND_BYTES;
						res.reply_length = 2'd2;
					end
				end
				usrh_pkg::REQ_CLEAR_FEATURE, usrh_pkg::REQ_SET_FEATURE: begin
					if (vlo == usrh_pkg::FEAT_REMOTE_WAKEUP &&
							recip == usrh_pkg::RCP_DEVICE) begin
						res.claimed = 1'b1;
						nwake = (code_s1 == usrh_pkg::REQ_SET_FEATURE);
					end else if (vlo == usrh_pkg::FEAT_ENDPOINT_HALT &&
							recip == usrh_pkg::RCP_ENDPOINT && epnum != 4'd0 && ep_ok) begin
						res.claimed = 1'b1;
						halt_we = 1'b1;
						halt_wd = (code_s1 == usrh_pkg::REQ_SET_FEATURE);
						res.endpoint_action = halt_wd ? usrh_pkg::ACT_STALL :
							usrh_pkg::ACT_UNSTALL;
					end
				end
				usrh_pkg::REQ_GET_INTERFACE: begin
					if (if_ok) begin
						res.claimed = 1'b1;
						res.reply_kind = usrh_pkg::KIND_BYTES;
						res.reply_byte_low = alt_val;
						res.reply_length = 2'd1;
					end
				end
				usrh_pkg::REQ_SET_INTERFACE: begin
					if (if_ok) begin
						res.claimed = 1'b1;
						alt_we = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		res.new_device_state = nstate;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_vld_q      <= 1'b0;
			dev_state_q    <= usrh_pkg::ST_DEFAULT;
			active_cfg_q   <= 8'd0;
			wakeup_q       <= 1'b0;
			self_powered_q <= 1'b1;
			alt_vld_q      <= '0;
			halt_vld_q     <= '0;
			alt_wen_q      <= 1'b0;
			halt_wen_q     <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == usrh_pkg::REG_SELF_POWERED) begin
				self_powered_q <= pwdata[0];
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (go_s1) begin
				out_vld_q <= valid_s1;
			end
			if (valid_s1 && go_s1) begin
				dev_state_q <= nstate;
				active_cfg_q <= ncfg;
				wakeup_q <= nwake;
				alt_wen_q <= alt_we;
				halt_wen_q <= halt_we;
				if (cfg_set) begin
					alt_vld_q <= '0;
					halt_vld_q <= '0;
				end
				if (alt_we) begin
					alt_vld_q[aidx_s1] <= 1'b1;
				end
				if (halt_we) begin
					halt_vld_q[hidx_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go_s1) begin
			out_q     <= res;
			alt_wa_q  <= aidx_s1;
			alt_wd_q  <= vlo;
			halt_wa_q <= hidx_s1;
			halt_wd_q <= halt_wd;
		end
	end

	assign out_quiet = out_q.reply_kind == usrh_pkg::KIND_NONE &&
		out_q.endpoint_action == usrh_pkg::ACT_NONE && !out_q.endpoints_reinit;
	assign out_cfg_state = out_q.new_device_state == usrh_pkg::ST_ADDRESSED ||
		out_q.new_device_state == usrh_pkg::ST_CONFIGURED;
	assign out_len_bad = out_q.reply_length != 2'd0 &&
		out_q.reply_kind != usrh_pkg::KIND_BYTES;

	`USRH_ASSERT(a_hold_s1, valid_s1 && !go_s1 |=> valid_s1 && $stable(code_s1), "held word lost")
	`USRH_ASSERT(a_unclaimed_quiet, out_vld_q && !out_q.claimed |-> out_quiet, "unclaimed reply")
	`USRH_ASSERT(a_reinit_state, out_vld_q && out_q.endpoints_reinit |-> out_cfg_state, "bad reinit")
	`USRH_NEVER(a_status_len, out_vld_q && out_len_bad, "reply length without reply bytes")

endmodule
